>>> hdl/prlu_pkg.sv
`default_nettype none

package prlu_pkg;

	localparam int REG_COUNT    = 32;
	localparam int WORD_BITS    = 32;
	localparam int REG_IDX_BITS = $clog2(REG_COUNT);
	localparam int FIELD_BITS   = 5;
	localparam int CR_BITS      = 4;
	localparam int Q_DEPTH      = 2;

	typedef enum logic [4:0] {
		OPC_XORI   = 5'd0,
		OPC_ORI    = 5'd1,
		OPC_ANDI   = 5'd2,
		OPC_XOR    = 5'd3,
		OPC_OR     = 5'd4,
		OPC_AND    = 5'd5,
		OPC_ANDC   = 5'd6,
		OPC_RLWIMI = 5'd7,
		OPC_RLWINM = 5'd8,
		OPC_RLWNM  = 5'd9,
		OPC_NAND   = 5'd10,
		OPC_NEG    = 5'd11,
		OPC_NOR    = 5'd12,
		OPC_CNTLZW = 5'd13,
		OPC_SLW    = 5'd14,
		OPC_SRAW   = 5'd15,
		OPC_SRAWI  = 5'd16,
		OPC_SRW    = 5'd17
	} opcode_t;

	typedef enum logic [3:0] {
		EX_NOP     = 4'd0,
		EX_XOR     = 4'd1,
		EX_OR      = 4'd2,
		EX_AND     = 4'd3,
		EX_ANDC    = 4'd4,
		EX_NAND    = 4'd5,
		EX_NOR     = 4'd6,
		EX_ROTMASK = 4'd7,
		EX_RLWIMI  = 4'd8,
		EX_NEG     = 4'd9,
		EX_CNTLZ   = 4'd10,
		EX_SLW     = 4'd11,
		EX_SRAW    = 4'd12,
		EX_SRW     = 4'd13
	} ex_op_t;

	typedef struct packed {
		logic [4:0]              opcode;
		logic [REG_IDX_BITS-1:0] src_reg;
		logic [REG_IDX_BITS-1:0] dst_reg;
		logic [REG_IDX_BITS-1:0] second_reg;
		logic [FIELD_BITS-1:0]   shift_imm;
		logic [FIELD_BITS-1:0]   mask_begin;
		logic [FIELD_BITS-1:0]   mask_end;
		logic [WORD_BITS-1:0]    immediate;
		logic                    record_bit;
		logic                    summary_ovf;
	} instr_t;

	typedef struct packed {
		logic [REG_IDX_BITS-1:0] written_reg;
		logic [WORD_BITS-1:0]    written_value;
		logic [CR_BITS-1:0]      cr0_value;
		logic                    cr0_written;
	} result_t;

	// Decoded instruction as it sits in the issue queue
	typedef struct packed {
		ex_op_t                  op;
		logic                    use_imm;
		logic                    amt_from_reg;
		logic                    wr_en;
		logic                    rec;
		logic                    so;
		logic [REG_IDX_BITS-1:0] src;
		logic [REG_IDX_BITS-1:0] sec;
		logic [REG_IDX_BITS-1:0] dst;
		logic [FIELD_BITS-1:0]   sh;
		logic [FIELD_BITS-1:0]   mb;
		logic [FIELD_BITS-1:0]   me;
		logic [WORD_BITS-1:0]    imm;
	} dec_item_t;

	typedef struct packed {
		logic                    en;
		logic [REG_IDX_BITS-1:0] src;
		logic [REG_IDX_BITS-1:0] sec;
		logic [REG_IDX_BITS-1:0] dst;
	} rf_rd_t;

	typedef struct packed {
		logic                    en;
		logic [REG_IDX_BITS-1:0] addr;
		logic [WORD_BITS-1:0]    data;
	} rf_wr_t;

endpackage

`default_nettype wire

>>> hdl/prlu_front.sv
`default_nettype none

module prlu_front import prlu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      instr_valid,
	output logic      instr_stall,
	input  instr_t    instr,
	output logic      q_valid,
	output dec_item_t q_item,
	input  logic      q_pop
);

	localparam int PtrBits = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CntBits = $clog2(Q_DEPTH + 1);

	dec_item_t            slot_q [Q_DEPTH];
	logic [PtrBits-1:0]   wr_ptr_q;
	logic [PtrBits-1:0]   rd_ptr_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 push;
	dec_item_t            dec;

	assign instr_stall = (cnt_q == CntBits'(Q_DEPTH));
	assign push        = instr_valid && !instr_stall;
	assign q_valid     = (cnt_q != '0);
	assign q_item      = slot_q[rd_ptr_q];

	// classify the opcode into an execute function and operand selects
	always_comb begin
		dec.op           = EX_NOP;
		dec.use_imm      = 1'b0;
		dec.amt_from_reg = 1'b0;
		dec.wr_en        = 1'b1;
		dec.rec          = instr.record_bit;
		dec.so           = instr.summary_ovf;
		dec.src          = instr.src_reg;
		dec.sec          = instr.second_reg;
		dec.dst          = instr.dst_reg;
		dec.sh           = instr.shift_imm;
		dec.mb           = instr.mask_begin;
		dec.me           = instr.mask_end;
		dec.imm          = instr.immediate;
		case (opcode_t'(instr.opcode))
			OPC_XORI: begin
				dec.op      = EX_XOR;
				dec.use_imm = 1'b1;
			end
			OPC_ORI: begin
				dec.op      = EX_OR;
				dec.use_imm = 1'b1;
			end
			OPC_ANDI: begin
				dec.op      = EX_AND;
				dec.use_imm = 1'b1;
				dec.rec     = 1'b1;
			end
			OPC_XOR:    dec.op = EX_XOR;
			OPC_OR:     dec.op = EX_OR;
			OPC_AND:    dec.op = EX_AND;
			OPC_ANDC:   dec.op = EX_ANDC;
			OPC_RLWIMI: dec.op = EX_RLWIMI;
			OPC_RLWINM: dec.op = EX_ROTMASK;
			OPC_RLWNM: begin
				dec.op           = EX_ROTMASK;
				dec.amt_from_reg = 1'b1;
			end
			OPC_NAND:   dec.op = EX_NAND;
			OPC_NEG:    dec.op = EX_NEG;
			OPC_NOR:    dec.op = EX_NOR;
			OPC_CNTLZW: dec.op = EX_CNTLZ;
			OPC_SLW: begin
				dec.op           = EX_SLW;
				dec.amt_from_reg = 1'b1;
			end
			OPC_SRAW: begin
				dec.op           = EX_SRAW;
				dec.amt_from_reg = 1'b1;
			end
			OPC_SRAWI:  dec.op = EX_SRAW;
			OPC_SRW: begin
				dec.op           = EX_SRW;
				dec.amt_from_reg = 1'b1;
			end
			default: begin
				// undefined opcode: no write, no CR0 update
				dec.op    = EX_NOP;
				dec.wr_en = 1'b0;
				dec.rec   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntBits'(Q_DEPTH))
		else $error("issue queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (cnt_q != '0))
		else $error("issue queue popped while empty");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("issue queue count lost a transfer");
`endif

endmodule

`default_nettype wire

>>> hdl/prlu_regfile.sv
`default_nettype none

module prlu_regfile import prlu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rf_rd_t               rd,
	input  rf_wr_t               wr,
	output logic [WORD_BITS-1:0] src_data,
	output logic [WORD_BITS-1:0] sec_data,
	output logic [WORD_BITS-1:0] dst_data
);

	// one bank per read port, all written together
	logic [WORD_BITS-1:0] mem_src_q [REG_COUNT];
	logic [WORD_BITS-1:0] mem_sec_q [REG_COUNT];
	logic [WORD_BITS-1:0] mem_dst_q [REG_COUNT];
	logic [REG_COUNT-1:0] written_q;
	logic [WORD_BITS-1:0] src_q;
	logic [WORD_BITS-1:0] sec_q;
	logic [WORD_BITS-1:0] dst_q;
	logic                 src_vld_q;
	logic                 sec_vld_q;
	logic                 dst_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_src_q[wr.addr] <= wr.data;
			mem_sec_q[wr.addr] <= wr.data;
			mem_dst_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			src_q <= mem_src_q[rd.src];
			sec_q <= mem_sec_q[rd.sec];
			dst_q <= mem_dst_q[rd.dst];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			src_vld_q <= 1'b0;
			sec_vld_q <= 1'b0;
			dst_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				src_vld_q <= written_q[rd.src];
				sec_vld_q <= written_q[rd.sec];
				dst_vld_q <= written_q[rd.dst];
			end
		end
	end

	assign src_data = src_vld_q ? src_q : '0;
	assign sec_data = sec_vld_q ? sec_q : '0;
	assign dst_data = dst_vld_q ? dst_q : '0;

endmodule

`default_nettype wire

>>> hdl/prlu_back.sv
`default_nettype none

module prlu_back import prlu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  dec_item_t q_item,
	output logic      q_pop,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	localparam logic [WORD_BITS-1:0] AllOnes = {WORD_BITS{1'b1}};

	function automatic logic [WORD_BITS-1:0] rot_left(input logic [WORD_BITS-1:0] v,
			input logic [FIELD_BITS-1:0] n);
		logic [2*WORD_BITS-1:0] w;
		w = {v, v} << n;
		return w[2*WORD_BITS-1:WORD_BITS];
	endfunction

	function automatic logic [WORD_BITS-1:0] build_mask(input logic [FIELD_BITS-1:0] mb,
			input logic [FIELD_BITS-1:0] me);
		logic [WORD_BITS-1:0] from_mb;
		logic [WORD_BITS-1:0] to_me;
		from_mb = AllOnes >> mb;
		to_me   = AllOnes << (FIELD_BITS'(WORD_BITS - 1) - me);
		return (mb <= me) ? (from_mb & to_me) : (from_mb | to_me);
	endfunction

	// five halving steps; zero input gives the full width
	function automatic logic [5:0] clz32(input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] w;
		logic [4:0]           n;
		w = v;
		n = '0;
		if (w[31:16] == 16'h0) begin
			n[4] = 1'b1;
			w    = w << 16;
		end
		if (w[31:24] == 8'h0) begin
			n[3] = 1'b1;
			w    = w << 8;
		end
		if (w[31:28] == 4'h0) begin
			n[2] = 1'b1;
			w    = w << 4;
		end
		if (w[31:30] == 2'h0) begin
			n[1] = 1'b1;
			w    = w << 2;
		end
		if (!w[31]) begin
			n[0] = 1'b1;
		end
		return (v == '0) ? 6'd32 : {1'b0, n};
	endfunction

	dec_item_t               item_s1;
	logic                    valid_s1;
	logic                    fire_s1;
	result_t                 result_s2;
	logic                    valid_s2;
	logic [CR_BITS-1:0]      cr0_q;
	logic                    lw_valid_q;
	logic [REG_IDX_BITS-1:0] lw_addr_q;
	logic [WORD_BITS-1:0]    lw_data_q;

	rf_rd_t                  rf_rd;
	rf_wr_t                  rf_wr;
	logic [WORD_BITS-1:0]    rf_src;
	logic [WORD_BITS-1:0]    rf_sec;
	logic [WORD_BITS-1:0]    rf_dst;

	logic [WORD_BITS-1:0]    op_s;
	logic [WORD_BITS-1:0]    op_b;
	logic [WORD_BITS-1:0]    op_a;
	logic [WORD_BITS-1:0]    op_bi;
	logic [5:0]              amt6;
	logic [WORD_BITS-1:0]    rot;
	logic [WORD_BITS-1:0]    mask;
	logic [WORD_BITS-1:0]    res;
	logic [CR_BITS-1:0]      cr0_new;
	logic                    is_lt;
	logic                    is_eq;

	assign fire_s1 = valid_s1 && (!valid_s2 || !result_stall);
	assign q_pop   = q_valid && (!valid_s1 || fire_s1);

	assign rf_rd.en  = q_pop;
	assign rf_rd.src = q_item.src;
	assign rf_rd.sec = q_item.sec;
	assign rf_rd.dst = q_item.dst;

	assign rf_wr.en   = fire_s1 && item_s1.wr_en;
	assign rf_wr.addr = item_s1.dst;
	assign rf_wr.data = res;

	prlu_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd       (rf_rd),
		.wr       (rf_wr),
		.src_data (rf_src),
		.sec_data (rf_sec),
		.dst_data (rf_dst)
	);

	// bypass the most recent write; the read issued alongside it saw old data
	assign op_s = (lw_valid_q && lw_addr_q == item_s1.src) ? lw_data_q : rf_src;
	assign op_b = (lw_valid_q && lw_addr_q == item_s1.sec) ? lw_data_q : rf_sec;
	assign op_a = (lw_valid_q && lw_addr_q == item_s1.dst) ? lw_data_q : rf_dst;

	assign op_bi = item_s1.use_imm ? item_s1.imm : op_b;
	assign amt6  = item_s1.amt_from_reg ? op_b[5:0] : {1'b0, item_s1.sh};
	assign rot   = rot_left(op_s, amt6[FIELD_BITS-1:0]);
	assign mask  = build_mask(item_s1.mb, item_s1.me);

	always_comb begin
		case (item_s1.op)
			EX_XOR:     res = op_s ^ op_bi;
			EX_OR:      res = op_s | op_bi;
			EX_AND:     res = op_s & op_bi;
			EX_ANDC:    res = op_s & ~op_b;
			EX_NAND:    res = ~(op_s & op_b);
			EX_NOR:     res = ~(op_s | op_b);
			EX_ROTMASK: res = rot & mask;
			EX_RLWIMI:  res = (rot & mask) | (op_a & ~mask);
			EX_NEG:     res = ~op_s + 1'b1;
			EX_CNTLZ:   res = {{(WORD_BITS - 6){1'b0}}, clz32(op_s)};
			EX_SLW:     res = amt6[5] ? '0 : (op_s << amt6[4:0]);
			EX_SRAW:    res = $signed(op_s) >>> amt6;
			EX_SRW:     res = amt6[5] ? '0 : (op_s >> amt6[4:0]);
			default:    res = op_a;
		endcase
	end

	assign is_lt   = res[WORD_BITS-1];
	assign is_eq   = (res == '0);
	assign cr0_new = {is_lt, !is_lt && !is_eq, is_eq, item_s1.so};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
		end
		if (fire_s1) begin
			result_s2.written_reg   <= item_s1.dst;
			result_s2.written_value <= res;
			result_s2.cr0_value     <= item_s1.rec ? cr0_new : cr0_q;
			result_s2.cr0_written   <= item_s1.rec;
		end
		if (fire_s1 && item_s1.wr_en) begin
			lw_addr_q <= item_s1.dst;
			lw_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			cr0_q      <= '0;
			lw_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
			if (fire_s1 && item_s1.rec) begin
				cr0_q <= cr0_new;
			end
			if (fire_s1 && item_s1.wr_en) begin
				lw_valid_q <= 1'b1;
			end
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef SYNTHESIS
	a_cr0_current: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.cr0_value == cr0_q))
		else $error("held CR0 differs from the pending result");

	a_bypass_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.wr_en) |=> (lw_valid_q && lw_addr_q == $past(item_s1.dst)))
		else $error("bypass register missed a register write");

	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(fire_s1))
		else $error("result register filled without an execute");
`endif

endmodule

`default_nettype wire

>>> hdl/ppc_logical_rotate_unit_core.sv
`default_nettype none

// Logical, rotate and shift execution unit for a 32-bit processor pipeline.
// Each transfer on the instr channel is one decoded instruction (xori, ori, andi.,
// xor, or, and, andc, rlwimi, rlwinm, rlwnm, nand, neg, nor, cntlzw, slw, sraw,
// srawi, srw); each transfer on the result channel reports the register written
// (always dst_reg), its new value, the CR0 field after the instruction and
// whether CR0 was updated. Undefined opcodes write nothing and report the
// unchanged destination register and CR0. The unit holds its own 32 x 32-bit
// register file and CR0, both zero after reset, with no clearing pass.
// Throughput is one instruction per clock while result_stall is low. From the
// instr transfer to the result being offered, an instruction waits in the issue
// queue, at the end of which the register file is read into its output registers,
// and then executes into the result register.
// The result of an instruction is bypassed to the one right behind it, so
// dependent instructions also issue back to back. The front end decodes into a
// two-entry queue and stalls only when that queue is full; the back end stalls
// only when its result register is held by result_stall.

module ppc_logical_rotate_unit_core import prlu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	output logic    instr_stall,
	input  instr_t  instr,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic      q_valid;
	logic      q_pop;
	dec_item_t q_item;

	// decode and buffer incoming transfers
	prlu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.instr_valid (instr_valid),
		.instr_stall (instr_stall),
		.instr       (instr),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	// read operands, execute, write back and hold the result for transfer
	prlu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> test/ppc_logical_rotate_unit_core_checker.sv
module ppc_logical_rotate_unit_core_checker import prlu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    instr_valid,
	input  logic    instr_stall,
	input  instr_t  instr,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      error_count,
	output int      pending_count
);

	logic [WORD_BITS-1:0] gpr [REG_COUNT];
	logic [CR_BITS-1:0]   cr_field;
	result_t              writeback_q [$];
	int                   fails = 0;

	function automatic logic [WORD_BITS-1:0] rotl(logic [WORD_BITS-1:0] v, logic [4:0] n);
		if (n == 5'd0)
			return v;
		return (v << n) | (v >> (6'd32 - n));
	endfunction

	// MB..ME mask, bit 0 is the MSB; wraps when MB > ME
	function automatic logic [WORD_BITS-1:0] span_mask(logic [4:0] mb, logic [4:0] me);
		logic [WORD_BITS-1:0] from_mb;
		logic [WORD_BITS-1:0] to_me;
		from_mb = 32'hffff_ffff >> mb;
		to_me   = 32'hffff_ffff << (5'd31 - me);
		return (mb <= me) ? (from_mb & to_me) : (from_mb | to_me);
	endfunction

	function automatic logic [WORD_BITS-1:0] sra_fill(logic [WORD_BITS-1:0] v, logic [5:0] n);
		logic signed [WORD_BITS-1:0] sv;
		sv = v;
		if (n >= 6'd32)
			return {WORD_BITS{v[WORD_BITS-1]}};
		return sv >>> n;
	endfunction

	// Execute one instruction against the shadow register file and CR0
	function automatic result_t execute_instr(instr_t it);
		logic [WORD_BITS-1:0] s, b, a, v, m;
		logic [5:0]           amt;
		logic                 known;
		logic                 rec;
		logic                 lt, eq;
		int                   n;
		result_t              r;
		s     = gpr[it.src_reg];
		b     = gpr[it.second_reg];
		a     = gpr[it.dst_reg];
		amt   = b[5:0];
		v     = a;
		known = 1'b1;
		rec   = it.record_bit;
		case (it.opcode)
			OPC_XORI:   v = s ^ it.immediate;
			OPC_ORI:    v = s | it.immediate;
			OPC_ANDI: begin
				v   = s & it.immediate;
				rec = 1'b1;
			end
			OPC_XOR:    v = s ^ b;
			OPC_OR:     v = s | b;
			OPC_AND:    v = s & b;
			OPC_ANDC:   v = s & ~b;
			OPC_RLWIMI: begin
				m = span_mask(it.mask_begin, it.mask_end);
				v = (rotl(s, it.shift_imm) & m) | (a & ~m);
			end
			OPC_RLWINM: v = rotl(s, it.shift_imm) & span_mask(it.mask_begin, it.mask_end);
			OPC_RLWNM:  v = rotl(s, b[4:0]) & span_mask(it.mask_begin, it.mask_end);
			OPC_NAND:   v = ~(s & b);
			OPC_NEG:    v = 32'd0 - s;
			OPC_NOR:    v = ~(s | b);
			OPC_CNTLZW: begin
				n = 0;
				while (n < WORD_BITS && !s[WORD_BITS-1-n])
					n++;
				v = n;
			end
			OPC_SLW:    v = (amt >= 6'd32) ? '0 : (s << amt);
			OPC_SRAW:   v = sra_fill(s, amt);
			OPC_SRAWI:  v = sra_fill(s, {1'b0, it.shift_imm});
			OPC_SRW:    v = (amt >= 6'd32) ? '0 : (s >> amt);
			default: begin
				known = 1'b0;
				rec   = 1'b0;
			end
		endcase
		if (known)
			gpr[it.dst_reg] = v;
		if (rec) begin
			lt       = v[WORD_BITS-1];
			eq       = (v == '0);
			cr_field = {lt, !lt && !eq, eq, it.summary_ovf};
		end
		r.written_reg   = it.dst_reg;
		r.written_value = v;
		r.cr0_value     = cr_field;
		r.cr0_written   = rec;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				gpr[i] = '0;
			cr_field = '0;
			writeback_q.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (writeback_q.size() == 0) begin
					$error("unexpected result transfer: reg %0d value %h",
						result.written_reg, result.written_value);
					fails++;
				end else begin
					want = writeback_q.pop_front();
					if (result.written_reg !== want.written_reg) begin
						$error("written_reg: expected %0d, got %0d",
							want.written_reg, result.written_reg);
						fails++;
					end
					if (result.written_value !== want.written_value) begin
						$error("written_value: expected %h, got %h",
							want.written_value, result.written_value);
						fails++;
					end
					if (result.cr0_value !== want.cr0_value) begin
						$error("cr0_value: expected %b, got %b",
							want.cr0_value, result.cr0_value);
						fails++;
					end
					if (result.cr0_written !== want.cr0_written) begin
						$error("cr0_written: expected %b, got %b",
							want.cr0_written, result.cr0_written);
						fails++;
					end
				end
			end
			if (instr_valid && !instr_stall)
				writeback_q.push_back(execute_instr(instr));
		end
		error_count   <= fails;
		pending_count <= writeback_q.size();
	end

endmodule

>>> test/tb_ppc_logical_rotate_unit_core.sv
module tb_ppc_logical_rotate_unit_core;
	import prlu_pkg::*;

	localparam int ITEM_COUNT     = 1750;
	localparam int QUIET_TAIL     = 150;   // trailing transfers with no idling on either side
	localparam int HOLD_AFTER     = 400;   // long result hold-off starts after this many transfers
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;     // settle time after the last expected result

	// opcodes the unit does not decode
	localparam logic [4:0] OPC_UNDEF_FIRST = 5'd18;
	localparam logic [4:0] OPC_UNDEF_LAST  = 5'd31;

	logic    clk;
	logic    arst_n;
	logic    instr_valid;
	logic    instr_stall;
	instr_t  instr;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	int fail_count;
	int pending_count;
	int sent = 0;
	int cycle_no = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	bit held = 1'b0;

	ppc_logical_rotate_unit_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr_valid),
		.instr_stall  (instr_stall),
		.instr        (instr),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	ppc_logical_rotate_unit_core_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.instr_valid   (instr_valid),
		.instr_stall   (instr_stall),
		.instr         (instr),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.error_count   (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset low, then release it on a falling edge
	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic instr_t mk(input logic [4:0] op, rs, ra, rb, sh, mb, me,
			input logic [WORD_BITS-1:0] imm, input logic rc, so);
		instr_t it;
		it.opcode      = op;
		it.src_reg     = rs;
		it.dst_reg     = ra;
		it.second_reg  = rb;
		it.shift_imm   = sh;
		it.mask_begin  = mb;
		it.mask_end    = me;
		it.immediate   = imm;
		it.record_bit  = rc;
		it.summary_ovf = so;
		return it;
	endfunction

	// Mostly legal instructions; a share of loads keeps the register file
	// full of fresh data, and narrow register picks exercise the bypass.
	function automatic instr_t random_instr();
		instr_t it;
		int     pick;
		it.src_reg     = 5'($urandom);
		it.dst_reg     = 5'($urandom);
		it.second_reg  = 5'($urandom);
		it.shift_imm   = 5'($urandom);
		it.mask_begin  = 5'($urandom);
		it.mask_end    = 5'($urandom);
		it.immediate   = $urandom;
		it.record_bit  = 1'($urandom);
		it.summary_ovf = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 20)
			it.opcode = 5'($urandom_range(int'(OPC_XORI), int'(OPC_ORI)));
		else if (pick < 96)
			it.opcode = 5'($urandom_range(int'(OPC_XORI), int'(OPC_SRW)));
		else
			it.opcode = 5'($urandom_range(OPC_UNDEF_FIRST, OPC_UNDEF_LAST));
		if ($urandom_range(0, 1)) begin
			it.src_reg    = 5'($urandom_range(0, 3));
			it.dst_reg    = 5'($urandom_range(0, 3));
			it.second_reg = 5'($urandom_range(0, 3));
		end
		case ($urandom_range(0, 7))
			0: it.immediate = '0;
			1: it.immediate = '1;
			default: ;
		endcase
		return it;
	endfunction

	// Watchdog: count cycles with no transfer on either channel
	always @(posedge clk) begin
		cycle_no++;
		if (arst_n) begin
			if ((instr_valid && !instr_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_ppc_logical_rotate_unit_core: errors");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, one long hold-off to back the unit up,
	// and no stalls at all during calm stretches and the quiet tail.
	initial begin
		int len;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent >= HOLD_AFTER) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
			end else if (!quiet && ((cycle_no / 150) % 3 != 2) && $urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 5);
				result_stall <= 1'b1;
				repeat (len) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Instruction side: directed instructions first, then random ones, then verdict
	initial begin
		instr_t directed_q [$];
		instr_t item;
		int     total;
		int     gap;
		instr_valid = 1'b0;
		instr       = '0;

		// Load boundary values: all ones (records LT), sign bit only, zero (records EQ),
		// shift amounts 32, 63 and 31, and a mixed pattern into the top register.
		directed_q.push_back(mk(OPC_ORI,  0, 1, 0, 0, 0, 0, 32'hffff_ffff, 1, 1));
		directed_q.push_back(mk(OPC_XORI, 0, 2, 0, 0, 0, 0, 32'h8000_0000, 0, 0));
		directed_q.push_back(mk(OPC_ORI,  0, 3, 0, 0, 0, 0, 32'h0000_0000, 1, 0));
		directed_q.push_back(mk(OPC_ORI,  0, 4, 0, 0, 0, 0, 32'd32, 0, 0));
		directed_q.push_back(mk(OPC_ORI,  0, 5, 0, 0, 0, 0, 32'd63, 0, 0));
		directed_q.push_back(mk(OPC_ORI,  0, 6, 0, 0, 0, 0, 32'd31, 0, 0));
		directed_q.push_back(mk(OPC_ORI,  0, 31, 0, 0, 0, 0, 32'ha5c3_0f96, 0, 1));
		// andi. records CR0 even with the record bit clear
		directed_q.push_back(mk(OPC_ANDI, 1, 7, 0, 0, 0, 0, 32'h7fff_ffff, 0, 1));
		directed_q.push_back(mk(OPC_XOR,  31, 8, 1, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(mk(OPC_OR,   2, 9, 31, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(mk(OPC_AND,  31, 10, 2, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(mk(OPC_ANDC, 31, 11, 2, 0, 0, 0, 0, 1, 1));
		// rlwimi with a wrapped mask merges into the old destination
		directed_q.push_back(mk(OPC_RLWIMI, 31, 8, 0, 8, 28, 3, 0, 1, 0));
		directed_q.push_back(mk(OPC_RLWINM, 31, 12, 0, 31, 0, 31, 0, 1, 0));
		// rlwnm takes only five bits of rB: 32 rotates by zero
		directed_q.push_back(mk(OPC_RLWNM, 31, 14, 4, 0, 5, 20, 0, 0, 0));
		directed_q.push_back(mk(OPC_NAND, 1, 15, 1, 0, 0, 0, 0, 1, 1));
		// neg of the most negative value stays put
		directed_q.push_back(mk(OPC_NEG,  2, 16, 0, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(mk(OPC_NOR,  3, 18, 3, 0, 0, 0, 0, 1, 0));
		// cntlzw of zero gives 32, of all ones gives 0
		directed_q.push_back(mk(OPC_CNTLZW, 3, 19, 0, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(mk(OPC_CNTLZW, 1, 20, 0, 0, 0, 0, 0, 0, 0));
		// register shifts by 32..63 clear, or fill with sign for sraw
		directed_q.push_back(mk(OPC_SLW,  1, 21, 4, 0, 0, 0, 0, 1, 1));
		directed_q.push_back(mk(OPC_SLW,  1, 22, 6, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(mk(OPC_SRAW, 2, 23, 5, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(mk(OPC_SRAW, 2, 24, 6, 0, 0, 0, 0, 0, 0));
		directed_q.push_back(mk(OPC_SRAWI, 31, 25, 0, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(mk(OPC_SRAWI, 2, 26, 0, 31, 0, 0, 0, 0, 0));
		directed_q.push_back(mk(OPC_SRW,  1, 27, 4, 0, 0, 0, 0, 1, 0));
		directed_q.push_back(mk(OPC_SRW,  1, 28, 6, 0, 0, 0, 0, 0, 0));
		// undefined opcodes write nothing and leave CR0 alone
		directed_q.push_back(mk(OPC_UNDEF_FIRST, 0, 1, 0, 0, 0, 0, 0, 1, 1));
		directed_q.push_back(mk(OPC_UNDEF_LAST, 31, 0, 31, 31, 31, 31, 32'hffff_ffff, 1, 1));

		total = directed_q.size() + ITEM_COUNT;
		@(posedge arst_n);
		@(negedge clk);
		for (int i = 0; i < total; i++) begin
			item  = (i < directed_q.size()) ? directed_q[i] : random_instr();
			quiet = (i >= total - QUIET_TAIL);
			// drop valid for a short burst, except in calm stretches and the tail
			if (!quiet && ((i / 100) % 3 != 1) && $urandom_range(0, 3) == 0) begin
				instr_valid <= 1'b0;
				gap = $urandom_range(1, 5);
				repeat (gap) @(negedge clk);
			end
			instr       <= item;
			instr_valid <= 1'b1;
			// hold the payload until the transfer happens
			do
				@(posedge clk);
			while (instr_stall);
			sent++;
			@(negedge clk);
		end
		instr_valid <= 1'b0;

		// drain: wait for every expected result, then let the pipe settle
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_ppc_logical_rotate_unit_core: clean");
		else
			$display("tb_ppc_logical_rotate_unit_core: errors");
		$finish;
	end

endmodule

>>> filelist.f
hdl/prlu_pkg.sv
hdl/prlu_front.sv
hdl/prlu_regfile.sv
hdl/prlu_back.sv
hdl/ppc_logical_rotate_unit_core.sv
test/ppc_logical_rotate_unit_core_checker.sv
test/tb_ppc_logical_rotate_unit_core.sv
